@@ design/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an implication holds on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks an implication that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/pfpm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package pfpm_pkg;
  localparam int FRAMES = 16;
  localparam int FIDX_W = 4;
  localparam int PIN_BITS = 8;
  localparam int PAGE_W = 31;
  localparam int MAX_RESULTS = 16;
  localparam logic [PIN_BITS-1:0] PIN_MAX = '1;

  typedef enum logic [1:0] {
    OP_PIN = 2'd0, OP_UNPIN = 2'd1, OP_DIRTY = 2'd2, OP_FLUSH = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_NOT_FOUND = 2'd1, ST_NO_FREE = 2'd2, ST_RSVD = 2'd3
  } status_t;

  localparam logic [1:0] REG_STRATEGY = 2'd0;
  localparam logic [1:0] REG_FRAMES = 2'd1;

  typedef struct packed {
    logic [1:0] operation;
    logic [30:0] page_number;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] frame_index;
    logic hit;
    logic fetch_request;
    logic write_back;
    logic [30:0] write_back_page;
    logic last;
    logic [31:0] write_count;
    logic [31:0] read_count;
  } out_item_t;

  // One frame record as stored in the frame memory.
  typedef struct packed {
    logic valid;
    logic [PAGE_W-1:0] page;
    logic [PIN_BITS-1:0] pins;
    logic dirty;
    logic [31:0] stamp;
  } frame_t;
endpackage
`default_nettype wire

@@ design/pfpm_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface pfpm_in_if;
  logic valid;
  logic ready;
  pfpm_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pfpm_out_if;
  logic valid;
  logic ready;
  pfpm_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ design/page_frame_pool_manager_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Page frame pool manager.
// Input channel "req" carries operation and page_number; output channel
// "rsp" carries one result per operation, or for flush one per write-back (one
// if there is none), with last set on the final result of each operation.
// Configuration: cfg_we/cfg_index/cfg_data write strategy (index 0) and
// frames_in_use (index 1); write only while the block is idle.
// Frame records live in one 16-entry memory with a registered read port.
// Every operation walks the frames in use, one memory read per cycle except
// where flush stops at a write-back; pin, unpin and mark dirty then update at
// most one frame, while flush clears the dirty bit of each frame it writes
// back. A write-back result is held back until the next one is found so that
// last can be set, and the walk pauses while the receiver stalls.
// req.ready is high only while the block is idle and the result register is
// empty. Reset (synchronous, rst high) clears every frame record through a
// sweep of all 16 frames before the first transaction is taken.
module page_frame_pool_manager_unit (
  input wire logic clk,
  input wire logic rst,
  pfpm_in_if.sink req,
  pfpm_out_if.source rsp,
  input wire logic cfg_we,
  input wire logic [1:0] cfg_index,
  input wire logic [4:0] cfg_data
);
  import pfpm_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_DECIDE, S_VREAD, S_VWAIT, S_WRITE, S_FEMIT,
    S_FDONE
  } state_t;

  state_t state;
  logic strategy;
  logic [4:0] frames_in_use;
  logic [31:0] stamp_counter, writes_done, reads_done;
  logic [FIDX_W-1:0] fifo_pointer;

  frame_t mem [FRAMES];
  logic mem_we;
  logic [FIDX_W-1:0] mem_waddr, mem_raddr;
  frame_t mem_wdata, rd;

  logic [1:0] op;
  logic [PAGE_W-1:0] page;
  logic [4:0] n, idx;
  logic [4:0] ridx;
  logic hit_f, empty_f, vic_f;
  logic [FIDX_W-1:0] hit_i, empty_i, vic_i, fvic_i, wr_i;
  logic fvic_f;
  logic [31:0] vic_stamp;
  frame_t wr_rec;
  logic out_valid;
  out_item_t out_data;
  logic out_free, femit_go, out_load;
  out_item_t out_next, held, held_rec;
  logic held_f;
  logic [FIDX_W-1:0] victim;
  logic [7:0] fp0, fp1, fp2, fp3, fp4;
  logic [4:0] fifo_p, dist_r, dist_v;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd <= mem[mem_raddr];
  end

  always_comb begin
    n = frames_in_use;
    if (n == 5'd0) n = 5'd1;
    if (n > 5'(FRAMES)) n = 5'(FRAMES);
  end

  // FIFO pointer reduced modulo n by restoring subtraction, then the distance
  // of ridx and of the current FIFO candidate from it, for wrapped order.
  always_comb begin
    fp0 = 8'(fifo_pointer);
    fp1 = (fp0 >= {n, 3'b000}) ? fp0 - {n, 3'b000} : fp0;
    fp2 = (fp1 >= {1'b0, n, 2'b00}) ? fp1 - {1'b0, n, 2'b00} : fp1;
    fp3 = (fp2 >= {2'b00, n, 1'b0}) ? fp2 - {2'b00, n, 1'b0} : fp2;
    fp4 = (fp3 >= {3'b000, n}) ? fp3 - {3'b000, n} : fp3;
    fifo_p = fp4[4:0];
    dist_r = (ridx >= fifo_p) ? ridx - fifo_p : ridx + n - fifo_p;
    dist_v = (5'(fvic_i) >= fifo_p) ? 5'(fvic_i) - fifo_p : 5'(fvic_i) + n - fifo_p;
  end

  assign req.ready = (state == S_IDLE) && !out_valid;
  assign rsp.valid = out_valid;
  assign rsp.data = out_data;

  assign out_free = !out_valid || rsp.ready;
  assign femit_go = (state == S_FEMIT) && (!held_f || out_free);
  assign victim = empty_f ? empty_i : (strategy ? vic_i : fvic_i);

  // Frame 0 is read while idle so that the walk starts right after acceptance.
  always_comb begin
    mem_raddr = idx[FIDX_W-1:0];
    if (state == S_IDLE) mem_raddr = '0;
    else if (state == S_VREAD) mem_raddr = vic_i;
  end

  // Every write lands before the next read of the same frame is issued.
  always_comb begin
    mem_we = 1'b0;
    mem_waddr = vic_i;
    mem_wdata = rd;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
      mem_waddr = idx[FIDX_W-1:0];
      mem_wdata = '0;
    end else if (femit_go) begin
      mem_we = 1'b1;
      mem_waddr = wr_i;
      mem_wdata = wr_rec;
      mem_wdata.dirty = 1'b0;
    end else if (state == S_WRITE) begin
      mem_we = 1'b1;
      if (op == OP_UNPIN) begin
        if (rd.pins != '0) mem_wdata.pins = rd.pins - PIN_BITS'(1);
      end else if (op == OP_DIRTY) begin
        mem_wdata.dirty = 1'b1;
      end else if (hit_f) begin
        if (rd.pins != PIN_MAX) mem_wdata.pins = rd.pins + PIN_BITS'(1);
        mem_wdata.stamp = stamp_counter + 32'd1;
      end else begin
        mem_wdata.valid = 1'b1;
        mem_wdata.page = page;
        mem_wdata.pins = PIN_BITS'(1);
        mem_wdata.dirty = 1'b0;
        mem_wdata.stamp = stamp_counter + 32'd1;
      end
    end
  end

  always_comb begin
    held_rec = '0;
    held_rec.frame_index = wr_i;
    held_rec.write_back = 1'b1;
    held_rec.write_back_page = wr_rec.page;
    held_rec.write_count = writes_done + 32'd1;
    held_rec.read_count = reads_done;
  end

  always_comb begin
    out_load = 1'b0;
    out_next = '0;
    out_next.last = 1'b1;
    out_next.write_count = writes_done;
    out_next.read_count = reads_done;
    unique case (state)
      S_FEMIT: begin
        if (femit_go && held_f) begin
          out_load = 1'b1;
          out_next = held;
        end
      end
      S_FDONE: begin
        if (out_free) begin
          out_load = 1'b1;
          if (held_f) begin
            out_next = held;
            out_next.last = 1'b1;
          end
        end
      end
      S_DECIDE: begin
        if (op != OP_PIN) begin
          out_load = 1'b1;
          if (hit_f) out_next.frame_index = hit_i;
          else out_next.status = ST_NOT_FOUND;
        end else if (!(hit_f || empty_f || vic_f)) begin
          out_load = 1'b1;
          out_next.status = ST_NO_FREE;
        end
      end
      S_WRITE: begin
        if (op == OP_PIN) begin
          out_load = 1'b1;
          out_next.frame_index = vic_i;
          if (hit_f) out_next.hit = 1'b1;
          else begin
            out_next.fetch_request = 1'b1;
            out_next.read_count = reads_done + 32'd1;
            if (!empty_f && rd.dirty) begin
              out_next.write_back = 1'b1;
              out_next.write_back_page = rd.page;
              out_next.write_count = writes_done + 32'd1;
            end
          end
        end
      end
      default: out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_load) begin
      out_valid <= 1'b1;
      out_data <= out_next;
    end else if (rsp.ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx <= '0;
      strategy <= 1'b0;
      frames_in_use <= 5'd16;
      stamp_counter <= '0;
      writes_done <= '0;
      reads_done <= '0;
      fifo_pointer <= '0;
      held_f <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_STRATEGY) strategy <= cfg_data[0];
        else if (cfg_index == REG_FRAMES) frames_in_use <= cfg_data;
      end
      unique case (state)
        S_CLEAR: begin
          if (idx == 5'(FRAMES - 1)) begin
            idx <= '0;
            state <= S_IDLE;
          end else idx <= idx + 5'd1;
        end
        S_IDLE: begin
          if (req.valid && req.ready) begin
            op <= req.data.operation;
            page <= req.data.page_number;
            idx <= 5'd1;
            ridx <= '0;
            hit_f <= 1'b0; empty_f <= 1'b0; vic_f <= 1'b0; fvic_f <= 1'b0;
            held_f <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // rd holds frame ridx (read issued in the previous cycle).
          if (op == OP_FLUSH) begin
            if (rd.valid && rd.pins == '0 && rd.dirty) begin
              wr_rec <= rd;
              wr_i <= ridx[FIDX_W-1:0];
              state <= S_FEMIT;
            end else if (ridx + 5'd1 >= n) state <= S_FDONE;
            else begin
              ridx <= ridx + 5'd1;
              idx <= idx + 5'd1;
            end
          end else begin
            if (!hit_f && rd.valid && rd.page == page) begin
              hit_f <= 1'b1; hit_i <= ridx[FIDX_W-1:0];
            end
            if (!empty_f && !rd.valid) begin
              empty_f <= 1'b1; empty_i <= ridx[FIDX_W-1:0];
            end
            if (rd.pins == '0) begin
              if (!vic_f || rd.stamp < vic_stamp) begin
                vic_f <= 1'b1; vic_i <= ridx[FIDX_W-1:0]; vic_stamp <= rd.stamp;
              end
              if (!fvic_f || dist_r < dist_v) begin
                fvic_f <= 1'b1; fvic_i <= ridx[FIDX_W-1:0];
              end
            end
            if (ridx + 5'd1 >= n) state <= S_DECIDE;
            else begin
              ridx <= ridx + 5'd1;
              idx <= idx + 5'd1;
            end
          end
        end
        S_FEMIT: begin
          if (femit_go) begin
            writes_done <= writes_done + 32'd1;
            held <= held_rec;
            held_f <= 1'b1;
            if (5'(wr_i) + 5'd1 >= n) begin
              state <= S_FDONE;
            end else begin
              // Re-read the next frame; the write above lands first.
              ridx <= 5'(wr_i) + 5'd1;
              idx <= 5'(wr_i) + 5'd1;
              state <= S_VWAIT;
            end
          end
        end
        S_VWAIT: begin
          // Waits here while the memory read of the next flush frame is issued.
          idx <= idx + 5'd1;
          state <= S_SCAN;
        end
        S_FDONE: begin
          if (out_free) begin
            held_f <= 1'b0;
            state <= S_IDLE;
          end
        end
        S_DECIDE: begin
          if (op != OP_PIN) state <= hit_f ? S_VREAD : S_IDLE;
          else if (hit_f || empty_f || vic_f) state <= S_VREAD;
          else state <= S_IDLE;
          vic_i <= hit_f ? hit_i : victim;
        end
        // The hit or victim frame is re-read for its full record.
        S_VREAD: state <= S_WRITE;
        S_WRITE: begin
          if (op == OP_PIN) begin
            stamp_counter <= stamp_counter + 32'd1;
            if (!hit_f) begin
              reads_done <= reads_done + 32'd1;
              if (!empty_f && !strategy)
                fifo_pointer <= (5'(vic_i) + 5'd1 >= n) ? '0 : vic_i + 4'd1;
              if (!empty_f && rd.dirty) writes_done <= writes_done + 32'd1;
            end
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_ready_idle, clk, rst, req.ready |-> state == S_IDLE, "ready outside idle")
  `ASSERT_IMPL(a_out_hold, clk, rst, (rsp.valid && !rsp.ready) |=> rsp.valid, "result dropped")
  `ASSERT_ALWAYS(a_reset_clear, clk, rst |=> state == S_CLEAR && !rsp.valid, "reset state")
endmodule
`default_nettype wire
